// ===== rtl/core/ioc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioc_pkg
// shared types and constants of the upper outlier clipper: input and result
// words, controller commands and datapath status
// ----------------------------------------------------------------------------
package ioc_pkg;

	localparam int MAX_ITEMS_DEF = 64;
	localparam int VALUE_W       = 32;
	// fence width: q3 plus 1.5 times a 33-bit spread, signed
	localparam int FENCE_W       = VALUE_W + 3;

	typedef struct packed {
		logic signed [VALUE_W-1:0] sample_value;
		logic                      batch_end;
	} ioc_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] damped_value;
		logic                      was_clipped;
		logic                      run_last;
	} ioc_result_t;

	typedef struct packed {
		logic load;
		logic idx_clr;
		logic scan;
		logic calc;
		logic emit;
	} ioc_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic emit_done;
	} ioc_stat_t;

endpackage

// ===== rtl/core/iqr_upper_outlier_clipper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqr_upper_outlier_clipper
// clips a batch of Q20.12 values to the upper outlier fence q3 + 1.5 * iqr
// ----------------------------------------------------------------------------
// Values are taken one per cycle while busy is low; each is written to the
// arrival-order memory and inserted into a sorted register row in the same
// cycle. A value with batch_end set closes the batch: busy then stays high
// through the row scan (the row shifts past its read tap to pick up q1 and
// q3), the spread step, and the memory reads, one per value. Results follow
// the reads through the read register and the result register, one per
// cycle, each shown for a single cycle with done high; they cannot be held
// off, so the receiver must take every word as it comes. Values past
// MAX_ITEMS in one batch are dropped.
// ----------------------------------------------------------------------------
module iqr_upper_outlier_clipper #(
	parameter int MAX_ITEMS = ioc_pkg::MAX_ITEMS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  ioc_pkg::ioc_item_t   item,
	output logic                 done,
	output ioc_pkg::ioc_result_t result
);

	ioc_pkg::ioc_cmd_t  cmd;
	ioc_pkg::ioc_stat_t stat;

	ioc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.batch_end (item.batch_end),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy)
	);

	ioc_datapath #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.result (result)
	);

	// closing word of a batch starts the busy phase
	a_close_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.batch_end) |=> busy)
		else $error("batch close did not raise busy");

	// a result word comes only from a read issued while busy
	a_done_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy, 2))
		else $error("result word without a preceding read");

	// the last word of a batch is never followed at once by another word
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.run_last) |=> !done)
		else $error("result word right after the end of a batch");

endmodule

// ===== rtl/core/ioc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioc_ctrl
// batch sequencer: load values, scan the sorted row for the quartiles,
// form the fence, then stream the stored batch out
// ----------------------------------------------------------------------------
module ioc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              batch_end,
	input  ioc_pkg::ioc_stat_t stat,
	output ioc_pkg::ioc_cmd_t  cmd,
	output logic              busy
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_CALC = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (batch_end) begin
						cmd.idx_clr = 1'b1;
						state_nxt   = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					cmd.idx_clr = 1'b1;
					state_nxt   = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.calc  = 1'b1;
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (stat.emit_done) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== rtl/core/ioc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioc_datapath
// arrival-order value memory, insertion-sorted register row, quartile
// capture, fence arithmetic and the clipping output stage
// ----------------------------------------------------------------------------
module ioc_datapath #(
	parameter int MAX_ITEMS = ioc_pkg::MAX_ITEMS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ioc_pkg::ioc_item_t   item,
	input  ioc_pkg::ioc_cmd_t    cmd,
	output ioc_pkg::ioc_stat_t   stat,
	output logic                 done,
	output ioc_pkg::ioc_result_t result
);

	localparam int VW = ioc_pkg::VALUE_W;
	localparam int FW = ioc_pkg::FENCE_W;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

	logic signed [VW-1:0] mem_q [MAX_ITEMS];
	logic signed [VW-1:0] cell_q [MAX_ITEMS];
	logic signed [VW-1:0] cell_nxt [MAX_ITEMS];
	logic [MAX_ITEMS-1:0] gt;

	logic [CW-1:0]   count_q;
	logic [CW-1:0]   idx_q;
	logic            load_en;
	logic [CW-1:0]   i1;
	logic [CW+1:0]   three_n;
	logic [CW-1:0]   i3;
	logic            emit_last;

	logic signed [VW-1:0] q1_q;
	logic signed [VW-1:0] q3_q;
	logic signed [FW-1:0] iqr_q;
	logic signed [FW-1:0] fence_q;

	logic signed [VW-1:0] rd_data_s1;
	logic                 rd_vld_s1;
	logic                 rd_last_s1;
	logic                 clip;

	assign load_en   = cmd.load && (count_q != CW'(MAX_ITEMS));
	assign i1        = count_q >> 2;
	assign three_n   = {2'b00, count_q} + {1'b0, count_q, 1'b0};
	assign i3        = three_n[CW+1:2];
	assign emit_last = (idx_q == count_q - CW'(1));

	assign stat.scan_done = (idx_q == i3);
	assign stat.emit_done = emit_last;

	// empty cells count as larger than anything; equal values stay ahead of v
	always_comb begin
		for (int i = 0; i < MAX_ITEMS; i++) begin
			gt[i] = (CW'(i) >= count_q) || (cell_q[i] > item.sample_value);
		end
		for (int i = 0; i < MAX_ITEMS; i++) begin
			if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
				cell_nxt[i] = cell_q[(i > 0) ? i - 1 : 0];
			end else if (gt[i]) begin
				cell_nxt[i] = item.sample_value;
			end else begin
				cell_nxt[i] = cell_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			cell_q <= cell_nxt;
		end else if (cmd.scan) begin
			// shift toward cell 0, which is the read tap
			for (int i = 0; i < MAX_ITEMS - 1; i++) begin
				cell_q[i] <= cell_q[i + 1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			mem_q[count_q[AW-1:0]] <= item.sample_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rd_data_s1 <= mem_q[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.emit && emit_last) begin
				count_q <= '0;
			end else if (load_en) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.scan || cmd.emit) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			if (idx_q == i1) begin
				q1_q <= cell_q[0];
			end
			if (idx_q == i3) begin
				q3_q <= cell_q[0];
			end
		end
		if (cmd.calc) begin
			iqr_q <= FW'(q3_q) - FW'(q1_q);
		end
		// spread is never negative, so the halving is a plain shift
		if (cmd.emit) begin
			fence_q <= FW'(q3_q) + iqr_q + (iqr_q >>> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			done      <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.emit;
			done      <= rd_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rd_last_s1 <= emit_last;
		end
	end

	assign clip = (FW'(rd_data_s1) > fence_q);

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			result.damped_value <= clip ? fence_q[VW-1:0] : rd_data_s1;
			result.was_clipped  <= clip;
			result.run_last     <= rd_last_s1;
		end
	end

endmodule
